@@ design/tasc_pkg.sv @@
// shared constants, codes and payload types of the trend aware segment cache
package tasc_pkg;

  // sizes
  localparam int NUM_PEERS  = 4;
  localparam int NUM_VIDEOS = 64;
  localparam int CAPACITY   = 64;

  // field widths
  localparam int OP_W     = 2;
  localparam int PEER_W   = $clog2(NUM_PEERS);
  localparam int VIDEO_W  = $clog2(NUM_VIDEOS);
  localparam int SEG_W    = 10;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int AVG_W    = 24;
  localparam int ORDER_W  = 16;
  localparam int W_W      = 16;
  localparam int CS_W     = 7;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;

  // derived sizes
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int SLOT_AW  = PEER_W + IDX_W;
  localparam int PAIR_AW  = PEER_W + VIDEO_W;
  localparam int SLOT_CNT = NUM_PEERS * CAPACITY;
  localparam int PAIR_CNT = NUM_PEERS * NUM_VIDEOS;
  localparam int MUL_W    = W_W + 1 + AVG_W;

  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam logic [W_W:0]     W_ONE   = {1'b1, {W_W{1'b0}}};

  // operation codes
  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MISS    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_CACHE_SIZE   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LONG_SMOOTH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_SHORT_SMOOTH = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_TREND_LIMIT  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [PEER_W-1:0]  peer_id;
    logic [VIDEO_W-1:0] video_id;
    logic [SEG_W-1:0]   segment_id;
    logic [TICK_W-1:0]  now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VIDEO_W-1:0]  evicted_video;
    logic [SEG_W-1:0]    evicted_segment;
    logic [FILL_W-1:0]   occupancy;
  } out_item_t;

  // one cache slot
  typedef struct packed {
    logic [VIDEO_W-1:0] video;
    logic [SEG_W-1:0]   segment;
    logic [ORDER_W-1:0] order;
  } slot_t;

  // popularity record of one peer and video
  typedef struct packed {
    logic [AVG_W-1:0]  long_avg;
    logic [AVG_W-1:0]  short_avg;
    logic [TICK_W-1:0] last_access;
    logic [FILL_W-1:0] segs;
  } pair_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] addr;
    logic               valid;
    slot_t              data;
  } slot_wr_t;

  typedef struct packed {
    logic               we;
    logic [PAIR_AW-1:0] addr;
    pair_t              data;
  } pair_wr_t;

  typedef struct packed {
    logic              start;
    logic [AVG_W-1:0]  long_avg;
    logic [AVG_W-1:0]  short_avg;
    logic [TICK_W-1:0] last_access;
  } pop_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] long_avg;
    logic [AVG_W-1:0] short_avg;
    logic             above;
  } pop_res_t;

endpackage

@@ design/tasc_slot_mem.sv @@
// slot memory of all peer caches with per-slot valid flags
module tasc_slot_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tasc_pkg::SLOT_AW-1:0] raddr_i,
  output tasc_pkg::slot_t              rdata_o,
  output logic                         rvalid_o,
  input  tasc_pkg::slot_wr_t           wr_i
);
  import tasc_pkg::*;

  slot_t               mem_q [SLOT_CNT];
  logic [SLOT_CNT-1:0] valid_q;
  slot_t               rdata_q;
  logic                rvalid_q;

  // storage array with registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // valid flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= wr_i.valid;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

@@ design/tasc_pair_mem.sv @@
// popularity memory per peer and video, unwritten entries read as zero
module tasc_pair_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tasc_pkg::PAIR_AW-1:0] raddr_i,
  output tasc_pkg::pair_t              rdata_o,
  input  tasc_pkg::pair_wr_t           wr_i
);
  import tasc_pkg::*;

  pair_t               mem_q [PAIR_CNT];
  logic [PAIR_CNT-1:0] valid_q;
  pair_t               rdata_q;
  logic                rvalid_q;

  // storage array with registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

@@ design/tasc_pop_unit.sv @@
// frequency reciprocal, long and short average blend and trend compare
module tasc_pop_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tasc_pkg::TICK_W-1:0] now_i,
  input  logic [tasc_pkg::W_W-1:0]    long_smooth_i,
  input  logic [tasc_pkg::W_W-1:0]    short_smooth_i,
  input  logic [tasc_pkg::W_W-1:0]    trend_limit_i,
  input  tasc_pkg::pop_req_t          req_i,
  output tasc_pkg::pop_res_t          res_o
);
  import tasc_pkg::*;

  localparam logic [1:0] PU_IDLE = 2'd0;
  localparam logic [1:0] PU_DIV  = 2'd1;
  localparam logic [1:0] PU_MUL  = 2'd2;

  logic [1:0]        state_q;
  logic [4:0]        cnt_q;
  logic [TICK_W-1:0] d_q;
  logic [TICK_W-1:0] rem_q;
  logic [AVG_W:0]    quo_q;
  logic [AVG_W-1:0]  f_q;
  logic [AVG_W-1:0]  long_q;
  logic [AVG_W-1:0]  short_q;
  logic [MUL_W-1:0]  prod_q;
  logic [MUL_W-1:0]  acc_q;
  logic [AVG_W-1:0]  lt_q;
  logic [AVG_W-1:0]  st_q;
  logic              above_q;
  logic              done_q;

  logic [TICK_W-1:0] dt;
  logic [TICK_W:0]   rem2;
  logic [TICK_W:0]   diff;
  logic              ge;
  logic [AVG_W:0]    quo_n;
  logic [W_W:0]      mul_a;
  logic [AVG_W-1:0]  mul_b;
  logic [MUL_W-1:0]  sum;

  // restoring divide step of 2^24 by dt, one quotient bit a cycle
  always_comb begin
    dt    = now_i - req_i.last_access;
    rem2  = {rem_q, (cnt_q == 5'(AVG_W))};
    ge    = rem2 >= {1'b0, d_q};
    diff  = rem2 - {1'b0, d_q};
    quo_n = {quo_q[AVG_W-1:0], ge};
    sum   = acc_q + prod_q;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cnt_q)
      5'd0: begin
        mul_a = {1'b0, long_smooth_i};
        mul_b = long_q;
      end
      5'd1: begin
        mul_a = W_ONE - {1'b0, long_smooth_i};
        mul_b = f_q;
      end
      5'd2: begin
        mul_a = {1'b0, short_smooth_i};
        mul_b = short_q;
      end
      5'd3: begin
        mul_a = W_ONE - {1'b0, short_smooth_i};
        mul_b = f_q;
      end
      5'd5: begin
        mul_a = {1'b0, trend_limit_i};
        mul_b = st_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer: divide (skipped when dt is at most one), then five products through one multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PU_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      d_q     <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      f_q     <= '0;
      long_q  <= '0;
      short_q <= '0;
      prod_q  <= '0;
      acc_q   <= '0;
      lt_q    <= '0;
      st_q    <= '0;
      above_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        PU_IDLE: begin
          if (req_i.start) begin
            long_q  <= req_i.long_avg;
            short_q <= req_i.short_avg;
            if (dt <= TICK_W'(1)) begin
              f_q     <= AVG_MAX;
              cnt_q   <= '0;
              state_q <= PU_MUL;
            end else begin
              d_q     <= dt;
              rem_q   <= '0;
              quo_q   <= '0;
              cnt_q   <= 5'(AVG_W);
              state_q <= PU_DIV;
            end
          end
        end
        PU_DIV: begin
          rem_q <= ge ? diff[TICK_W-1:0] : rem2[TICK_W-1:0];
          quo_q <= quo_n;
          if (cnt_q == '0) begin
            f_q     <= quo_n[AVG_W-1:0];
            state_q <= PU_MUL;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        PU_MUL: begin
          prod_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
          cnt_q  <= cnt_q + 5'd1;
          unique case (cnt_q)
            5'd1: acc_q <= prod_q;
            5'd2: lt_q  <= sum[AVG_W+W_W-1:W_W];
            5'd3: acc_q <= prod_q;
            5'd4: st_q  <= sum[AVG_W+W_W-1:W_W];
            5'd6: begin
              above_q <= {{(MUL_W-AVG_W-8){1'b0}}, lt_q, 8'b0} > prod_q;
              done_q  <= 1'b1;
              state_q <= PU_IDLE;
            end
            default: begin
            end
          endcase
        end
        default: state_q <= PU_IDLE;
      endcase
    end
  end

  assign res_o.done      = done_q;
  assign res_o.long_avg  = lt_q;
  assign res_o.short_avg = st_q;
  assign res_o.above     = above_q;

endmodule

@@ design/trend_aware_segment_cache_policy.sv @@
// Trend aware segment cache policy: one item in flight, results through an output register.
// Each item with a known op first scans the addressed peer's 64 slots, one slot memory read a
// cycle; an item with an unknown op skips the scan. A presence check ends there. An
// access adds one popularity update through the 25 step reciprocal divider and five
// products through the single multiplier. An add of a missing segment into a peer
// below its size limit adds a second slot scan, then writes back the new slot and the
// popularity record. An add into a full peer also walks all 64 videos of that peer,
// passing each video that holds segments through the popularity unit (the divider
// is skipped when its last access is this tick or the one before), and runs a third
// slot scan. No clearing pass is needed after reset. The next item is taken while the
// last result waits.
module trend_aware_segment_cache_policy (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tasc_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tasc_pkg::out_item_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [tasc_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [tasc_pkg::CFG_DW-1:0] cfg_data_i
);
  import tasc_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FIND      = 4'd1;
  localparam logic [3:0] S_ACC_RD    = 4'd2;
  localparam logic [3:0] S_ACC_START = 4'd3;
  localparam logic [3:0] S_ACC_POP   = 4'd4;
  localparam logic [3:0] S_INS_SCAN  = 4'd5;
  localparam logic [3:0] S_INS_WR    = 4'd6;
  localparam logic [3:0] S_INS_PWB   = 4'd7;
  localparam logic [3:0] S_VIC_RD    = 4'd8;
  localparam logic [3:0] S_VIC_CHK   = 4'd9;
  localparam logic [3:0] S_VIC_POP   = 4'd10;
  localparam logic [3:0] S_EV_SCAN   = 4'd11;
  localparam logic [3:0] S_EV_CLR    = 4'd12;
  localparam logic [3:0] S_EV_PWB    = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  // configuration registers
  logic [CS_W-1:0] cache_size_q;
  logic [W_W-1:0]  long_smooth_q;
  logic [W_W-1:0]  short_smooth_q;
  logic [W_W-1:0]  trend_limit_q;

  // control and working registers
  logic [3:0]         state_q, state_d;
  in_item_t           item_q, item_d;
  logic [FILL_W-1:0]  sc_q, sc_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic               hit_q, hit_d;
  logic               free_found_q, free_found_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic               evicted_q, evicted_d;
  logic [VIDEO_W-1:0] victim_q, victim_d;
  logic               ev_found_q, ev_found_d;
  logic [IDX_W-1:0]   ev_idx_q, ev_idx_d;
  logic [SEG_W-1:0]   ev_seg_q, ev_seg_d;
  logic [ORDER_W-1:0] maxo_q, maxo_d;
  logic [VIDEO_W-1:0] vid_q, vid_d;
  logic               best_found_q, best_found_d;
  logic [VIDEO_W-1:0] best_v_q, best_v_d;
  logic [AVG_W-1:0]   best_l_q, best_l_d;
  logic               any_found_q, any_found_d;
  logic [VIDEO_W-1:0] any_v_q, any_v_d;
  logic [AVG_W-1:0]   any_l_q, any_l_d;
  pair_t              hold_q, hold_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [FILL_W-1:0]  fill_q [NUM_PEERS];
  logic               fill_inc, fill_dec;

  // memory and unit connections
  logic [SLOT_AW-1:0] slot_raddr;
  slot_t              slot_rdata;
  logic               slot_rvalid;
  slot_wr_t           slot_wr;
  logic [PAIR_AW-1:0] pair_raddr;
  pair_t              pair_rdata;
  pair_wr_t           pair_wr;
  pop_req_t           pop_req;
  pop_res_t           pop_res;

  logic [PEER_W-1:0] peer;
  logic [FILL_W-1:0] limit;
  logic              in_xfer;
  logic              scan_end;
  logic              vic_last;

  tasc_slot_mem u_slot_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .raddr_i  (slot_raddr),
    .rdata_o  (slot_rdata),
    .rvalid_o (slot_rvalid),
    .wr_i     (slot_wr)
  );

  tasc_pair_mem u_pair_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (pair_raddr),
    .rdata_o (pair_rdata),
    .wr_i    (pair_wr)
  );

  tasc_pop_unit u_pop_unit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .now_i          (item_q.now_ticks),
    .long_smooth_i  (long_smooth_q),
    .short_smooth_i (short_smooth_q),
    .trend_limit_i  (trend_limit_q),
    .req_i          (pop_req),
    .res_o          (pop_res)
  );

  assign peer       = item_q.peer_id;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign scan_end   = (sc_q == FILL_W'(CAPACITY)) && !pend_q;
  assign vic_last   = (vid_q == VIDEO_W'(NUM_VIDEOS - 1));

  // effective cache size, clamped to one slot up to the full capacity
  always_comb begin
    if (cache_size_q == '0) begin
      limit = FILL_W'(1);
    end else if (FILL_W'(cache_size_q) > FILL_W'(CAPACITY)) begin
      limit = FILL_W'(CAPACITY);
    end else begin
      limit = FILL_W'(cache_size_q);
    end
  end

  // item sequencer
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    sc_d         = sc_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    status_d     = status_q;
    evicted_d    = evicted_q;
    victim_d     = victim_q;
    ev_found_d   = ev_found_q;
    ev_idx_d     = ev_idx_q;
    ev_seg_d     = ev_seg_q;
    maxo_d       = maxo_q;
    vid_d        = vid_q;
    best_found_d = best_found_q;
    best_v_d     = best_v_q;
    best_l_d     = best_l_q;
    any_found_d  = any_found_q;
    any_v_d      = any_v_q;
    any_l_d      = any_l_q;
    hold_d       = hold_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    fill_inc     = 1'b0;
    fill_dec     = 1'b0;

    slot_raddr    = {peer, sc_q[IDX_W-1:0]};
    slot_wr       = '0;
    pair_raddr    = {peer, item_q.video_id};
    pair_wr       = '0;
    pop_req       = '0;
    pop_req.long_avg    = pair_rdata.long_avg;
    pop_req.short_avg   = pair_rdata.short_avg;
    pop_req.last_access = pair_rdata.last_access;

    // slot scan issue, shared by the three scanning states
    if ((state_q == S_FIND || state_q == S_INS_SCAN || state_q == S_EV_SCAN) &&
        (sc_q != FILL_W'(CAPACITY))) begin
      sc_d       = sc_q + FILL_W'(1);
      pend_d     = 1'b1;
      pend_idx_d = sc_q[IDX_W-1:0];
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          item_d       = in_data_i;
          sc_d         = '0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          evicted_d    = 1'b0;
          ev_found_d   = 1'b0;
          ev_seg_d     = '0;
          victim_d     = '0;
          status_d     = ST_MISS;
          if (in_data_i.op == OP_ACCESS || in_data_i.op == OP_ADD ||
              in_data_i.op == OP_CHECK) begin
            state_d = S_FIND;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      // look for the requested segment
      S_FIND: begin
        if (pend_q && slot_rvalid && slot_rdata.video == item_q.video_id &&
            slot_rdata.segment == item_q.segment_id) begin
          hit_d = 1'b1;
        end
        if (scan_end) begin
          status_d = hit_q ? ST_HIT : ST_MISS;
          priority if (item_q.op == OP_ACCESS) begin
            state_d = S_ACC_RD;
          end else if (item_q.op == OP_ADD && !hit_q) begin
            sc_d = '0;
            if (fill_q[peer] < limit) begin
              state_d = S_INS_SCAN;
            end else begin
              vid_d        = '0;
              best_found_d = 1'b0;
              any_found_d  = 1'b0;
              state_d      = S_VIC_RD;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end

      // popularity update of an access
      S_ACC_RD: begin
        state_d = S_ACC_START;
      end
      S_ACC_START: begin
        pop_req.start = 1'b1;
        hold_d        = pair_rdata;
        state_d       = S_ACC_POP;
      end
      S_ACC_POP: begin
        if (pop_res.done) begin
          pair_wr.we               = 1'b1;
          pair_wr.addr             = {peer, item_q.video_id};
          pair_wr.data.long_avg    = pop_res.long_avg;
          pair_wr.data.short_avg   = pop_res.short_avg;
          pair_wr.data.last_access = item_q.now_ticks;
          pair_wr.data.segs        = hold_q.segs;
          state_d                  = S_DONE;
        end
      end

      // age the video's segments and find the first free slot
      S_INS_SCAN: begin
        if (pend_q) begin
          if (slot_rvalid) begin
            if (slot_rdata.video == item_q.video_id) begin
              slot_wr.we         = 1'b1;
              slot_wr.addr       = {peer, pend_idx_q};
              slot_wr.valid      = 1'b1;
              slot_wr.data       = slot_rdata;
              slot_wr.data.order = slot_rdata.order + ORDER_W'(1);
            end
          end else if (!free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = pend_idx_q;
          end
        end
        if (scan_end) begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        slot_wr.we           = 1'b1;
        slot_wr.addr         = {peer, free_idx_q};
        slot_wr.valid        = 1'b1;
        slot_wr.data.video   = item_q.video_id;
        slot_wr.data.segment = item_q.segment_id;
        slot_wr.data.order   = '0;
        state_d              = S_INS_PWB;
      end
      S_INS_PWB: begin
        pair_wr.we        = 1'b1;
        pair_wr.addr      = {peer, item_q.video_id};
        pair_wr.data      = pair_rdata;
        pair_wr.data.segs = pair_rdata.segs + FILL_W'(1);
        fill_inc          = 1'b1;
        status_d          = evicted_q ? ST_EVICTED : ST_ADDED;
        state_d           = S_DONE;
      end

      // victim search over the peer's videos
      S_VIC_RD: begin
        pair_raddr = {peer, vid_q};
        state_d    = S_VIC_CHK;
      end
      S_VIC_CHK: begin
        if (pair_rdata.segs != '0) begin
          pop_req.start = 1'b1;
          state_d       = S_VIC_POP;
        end
      end
      S_VIC_POP: begin
        if (pop_res.done) begin
          if (pop_res.above && (!best_found_q || pop_res.long_avg < best_l_q)) begin
            best_found_d = 1'b1;
            best_v_d     = vid_q;
            best_l_d     = pop_res.long_avg;
          end
          if (!any_found_q || pop_res.long_avg < any_l_q) begin
            any_found_d = 1'b1;
            any_v_d     = vid_q;
            any_l_d     = pop_res.long_avg;
          end
        end
      end

      // oldest segment of the victim
      S_EV_SCAN: begin
        if (pend_q && slot_rvalid && slot_rdata.video == victim_q &&
            (!ev_found_q || slot_rdata.order > maxo_q)) begin
          ev_found_d = 1'b1;
          maxo_d     = slot_rdata.order;
          ev_idx_d   = pend_idx_q;
          ev_seg_d   = slot_rdata.segment;
        end
        if (scan_end) begin
          if (ev_found_q) begin
            state_d = S_EV_CLR;
          end else begin
            status_d = ST_MISS;
            state_d  = S_DONE;
          end
        end
      end
      S_EV_CLR: begin
        slot_wr.we    = 1'b1;
        slot_wr.addr  = {peer, ev_idx_q};
        slot_wr.valid = 1'b0;
        pair_raddr    = {peer, victim_q};
        state_d       = S_EV_PWB;
      end
      S_EV_PWB: begin
        pair_wr.we        = 1'b1;
        pair_wr.addr      = {peer, victim_q};
        pair_wr.data      = pair_rdata;
        pair_wr.data.segs = pair_rdata.segs - FILL_W'(1);
        fill_dec          = 1'b1;
        evicted_d         = 1'b1;
        free_found_d      = 1'b0;
        sc_d              = '0;
        state_d           = S_INS_SCAN;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status          = status_q;
          out_d.evicted_video   = evicted_q ? victim_q : '0;
          out_d.evicted_segment = evicted_q ? ev_seg_q : '0;
          out_d.occupancy       = fill_q[peer];
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // step to the next video or settle the victim
    if ((state_q == S_VIC_CHK && pair_rdata.segs == '0) ||
        (state_q == S_VIC_POP && pop_res.done)) begin
      if (vic_last) begin
        priority if (best_found_d) begin
          victim_d   = best_v_d;
          ev_found_d = 1'b0;
          sc_d       = '0;
          state_d    = S_EV_SCAN;
        end else if (any_found_d) begin
          victim_d   = any_v_d;
          ev_found_d = 1'b0;
          sc_d       = '0;
          state_d    = S_EV_SCAN;
        end else begin
          status_d = ST_MISS;
          state_d  = S_DONE;
        end
      end else begin
        vid_d   = vid_q + VIDEO_W'(1);
        state_d = S_VIC_RD;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_size_q   <= CS_W'(64);
      long_smooth_q  <= W_W'(62259);
      short_smooth_q <= W_W'(52429);
      trend_limit_q  <= W_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CACHE_SIZE:   cache_size_q   <= cfg_data_i[CS_W-1:0];
        CFG_LONG_SMOOTH:  long_smooth_q  <= cfg_data_i[W_W-1:0];
        CFG_SHORT_SMOOTH: short_smooth_q <= cfg_data_i[W_W-1:0];
        CFG_TREND_LIMIT:  trend_limit_q  <= cfg_data_i[W_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // per-peer fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PEERS; p++) begin
        fill_q[p] <= '0;
      end
    end else if (fill_inc) begin
      fill_q[peer] <= fill_q[peer] + FILL_W'(1);
    end else if (fill_dec) begin
      fill_q[peer] <= fill_q[peer] - FILL_W'(1);
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      sc_q         <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      status_q     <= ST_MISS;
      evicted_q    <= 1'b0;
      victim_q     <= '0;
      ev_found_q   <= 1'b0;
      ev_idx_q     <= '0;
      ev_seg_q     <= '0;
      maxo_q       <= '0;
      vid_q        <= '0;
      best_found_q <= 1'b0;
      best_v_q     <= '0;
      best_l_q     <= '0;
      any_found_q  <= 1'b0;
      any_v_q      <= '0;
      any_l_q      <= '0;
      hold_q       <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      sc_q         <= sc_d;
      pend_q       <= pend_d;
      pend_idx_q   <= pend_idx_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      status_q     <= status_d;
      evicted_q    <= evicted_d;
      victim_q     <= victim_d;
      ev_found_q   <= ev_found_d;
      ev_idx_q     <= ev_idx_d;
      ev_seg_q     <= ev_seg_d;
      maxo_q       <= maxo_d;
      vid_q        <= vid_d;
      best_found_q <= best_found_d;
      best_v_q     <= best_v_d;
      best_l_q     <= best_l_d;
      any_found_q  <= any_found_d;
      any_v_q      <= any_v_d;
      any_l_q      <= any_l_d;
      hold_q       <= hold_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a peer never holds more than its slot count
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[peer] <= FILL_W'(CAPACITY))
    else $error("peer fill count above capacity");

  // slot scan pointer stays within one peer
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= FILL_W'(CAPACITY))
    else $error("slot scan pointer out of range");

  // popularity results arrive only while the sequencer waits for them
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_res.done |-> (state_q == S_ACC_POP || state_q == S_VIC_POP))
    else $error("popularity result with nobody waiting");

  // eviction only on an add
  a_evict_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV_SCAN || state_q == S_VIC_RD) |-> (item_q.op == OP_ADD))
    else $error("eviction path entered by a non-add transfer");

endmodule

@@ test/tb_trend_aware_segment_cache_policy.sv @@
// testbench of the trend aware segment cache policy: directed table, random traffic, predictor
module tb_trend_aware_segment_cache_policy;
  import tasc_pkg::*;

  localparam int MAX_CYCLES = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  trend_aware_segment_cache_policy u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // cache mirror
  logic [6:0]  mir_cache_size;
  logic [15:0] mir_long_w, mir_short_w, mir_trend;
  logic        mir_valid   [SLOT_CNT];
  logic [5:0]  mir_video   [SLOT_CNT];
  logic [9:0]  mir_seg     [SLOT_CNT];
  logic [15:0] mir_order   [SLOT_CNT];
  logic [6:0]  mir_fill    [NUM_PEERS];
  logic [23:0] mir_long    [PAIR_CNT];
  logic [23:0] mir_short   [PAIR_CNT];
  logic [31:0] mir_last    [PAIR_CNT];
  logic [6:0]  mir_segs    [PAIR_CNT];

  out_item_t pending_results[$];
  out_item_t last_got = '0;
  int errors = 0;
  int cycles = 0;
  bit hold_long = 0;
  bit sender_busy = 0;

  function automatic logic [23:0] freq_of(logic [31:0] dt);
    if (dt <= 1) return 24'hFFFFFF;
    return 25'h1000000 / dt;
  endfunction

  function automatic logic [23:0] smooth(logic [15:0] w, logic [23:0] old, logic [23:0] f);
    logic [47:0] acc;
    acc = 48'(w) * old + (48'h10000 - 48'(w)) * f;
    return acc[39:16];
  endfunction

  function automatic int slot_of(int peer, logic [5:0] v, logic [9:0] s);
    for (int i = 0; i < CAPACITY; i++)
      if (mir_valid[peer*CAPACITY+i] && mir_video[peer*CAPACITY+i] == v
          && mir_seg[peer*CAPACITY+i] == s) return i;
    return -1;
  endfunction

  function automatic void store_seg(int peer, logic [5:0] v, logic [9:0] s);
    int fs;
    fs = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (mir_valid[peer*CAPACITY+i]) begin
        if (mir_video[peer*CAPACITY+i] == v) mir_order[peer*CAPACITY+i]++;
      end else if (fs < 0) fs = i;
    end
    if (fs < 0) return;
    mir_valid[peer*CAPACITY+fs] = 1;
    mir_video[peer*CAPACITY+fs] = v;
    mir_seg[peer*CAPACITY+fs] = s;
    mir_order[peer*CAPACITY+fs] = 0;
    mir_segs[peer*NUM_VIDEOS+v]++;
    mir_fill[peer]++;
  endfunction

  function automatic int choose_victim(int peer, logic [31:0] now);
    int best, any;
    logic [23:0] bl, al, f, lt, st;
    best = -1; any = -1; bl = 0; al = 0;
    for (int v = 0; v < NUM_VIDEOS; v++) begin
      int k;
      k = peer*NUM_VIDEOS + v;
      if (mir_segs[k] == 0) continue;
      f = freq_of(now - mir_last[k]);
      lt = smooth(mir_long_w, mir_long[k], f);
      st = smooth(mir_short_w, mir_short[k], f);
      if (64'(lt) * 256 > 64'(mir_trend) * st)
        if (best < 0 || lt < bl) begin best = v; bl = lt; end
      if (any < 0 || lt < al) begin any = v; al = lt; end
    end
    return best >= 0 ? best : any;
  endfunction

  function automatic out_item_t cache_step(in_item_t it);
    out_item_t r;
    int peer, k, lim, vic, sl;
    logic [23:0] f;
    logic [15:0] mo;
    r = '0;
    peer = it.peer_id;
    k = peer*NUM_VIDEOS + it.video_id;
    if (it.op == OP_ACCESS) begin
      f = freq_of(it.now_ticks - mir_last[k]);
      r.status = slot_of(peer, it.video_id, it.segment_id) >= 0 ? ST_HIT : ST_MISS;
      mir_last[k] = it.now_ticks;
      mir_long[k] = smooth(mir_long_w, mir_long[k], f);
      mir_short[k] = smooth(mir_short_w, mir_short[k], f);
    end else if (it.op == OP_CHECK) begin
      r.status = slot_of(peer, it.video_id, it.segment_id) >= 0 ? ST_HIT : ST_MISS;
    end else if (it.op == OP_ADD) begin
      lim = mir_cache_size;
      if (lim < 1) lim = 1;
      if (lim > CAPACITY) lim = CAPACITY;
      if (slot_of(peer, it.video_id, it.segment_id) >= 0) r.status = ST_HIT;
      else if (mir_fill[peer] < lim) begin
        store_seg(peer, it.video_id, it.segment_id);
        r.status = ST_ADDED;
      end else begin
        vic = choose_victim(peer, it.now_ticks);
        sl = -1; mo = 0;
        if (vic >= 0)
          for (int i = 0; i < CAPACITY; i++)
            if (mir_valid[peer*CAPACITY+i] && mir_video[peer*CAPACITY+i] == vic
                && (sl < 0 || mir_order[peer*CAPACITY+i] > mo)) begin
              sl = i; mo = mir_order[peer*CAPACITY+i];
            end
        if (sl >= 0) begin
          r.evicted_video = mir_video[peer*CAPACITY+sl];
          r.evicted_segment = mir_seg[peer*CAPACITY+sl];
          mir_valid[peer*CAPACITY+sl] = 0;
          mir_segs[peer*NUM_VIDEOS+r.evicted_video]--;
          mir_fill[peer]--;
          store_seg(peer, it.video_id, it.segment_id);
          r.status = ST_EVICTED;
        end
      end
    end
    r.occupancy = mir_fill[peer];
    return r;
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stall, long hold on request, compare
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          errors++;
        end else begin
          out_item_t e;
          e = pending_results.pop_front();
          last_got = out_data_o;
          if (e.status !== out_data_o.status)
            $display("%0t: status exp %0d got %0d", $time, e.status, out_data_o.status);
          if (e.evicted_video !== out_data_o.evicted_video)
            $display("%0t: evicted_video exp %0d got %0d", $time,
                     e.evicted_video, out_data_o.evicted_video);
          if (e.evicted_segment !== out_data_o.evicted_segment)
            $display("%0t: evicted_segment exp %0d got %0d", $time,
                     e.evicted_segment, out_data_o.evicted_segment);
          if (e.occupancy !== out_data_o.occupancy)
            $display("%0t: occupancy exp %0d got %0d", $time, e.occupancy, out_data_o.occupancy);
          if (e !== out_data_o) errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (hold_long) begin
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // transfer one item, with optional gap first; valid stays up after the transfer
  task automatic send_item(in_item_t it, bit gaps);
    int g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 300) : $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    pending_results.push_back(cache_step(it));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_CACHE_SIZE:   mir_cache_size = val[6:0];
      CFG_LONG_SMOOTH:  mir_long_w = val;
      CFG_SHORT_SMOOTH: mir_short_w = val;
      default:          mir_trend = val;
    endcase
  endtask

  typedef struct {
    logic [1:0] op; logic [1:0] peer; logic [5:0] video; logic [9:0] seg; logic [31:0] now;
    bit known; out_item_t exp_res;
  } row_t;

  row_t rows[$];
  logic [31:0] clock_now = 32'd1000;

  function automatic in_item_t rand_item(int vmax, int smax);
    in_item_t it;
    int r;
    r = $urandom_range(0, 9);
    it.op = r < 5 ? OP_ADD : (r < 8 ? OP_ACCESS : OP_CHECK);
    it.peer_id = PEER_W'($urandom_range(0, NUM_PEERS-1));
    it.video_id = VIDEO_W'($urandom_range(0, vmax));
    it.segment_id = SEG_W'(($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, smax));
    if ($urandom_range(0, 29) == 0) it.now_ticks = $urandom;
    else begin
      clock_now = clock_now + $urandom_range(0, 200);
      it.now_ticks = clock_now;
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    out_item_t got;
    mir_cache_size = 64; mir_long_w = 62259; mir_short_w = 52429; mir_trend = 256;
    for (int i = 0; i < SLOT_CNT; i++) begin
      mir_valid[i] = 0; mir_video[i] = 0; mir_seg[i] = 0; mir_order[i] = 0;
    end
    for (int i = 0; i < PAIR_CNT; i++) begin
      mir_long[i] = 0; mir_short[i] = 0; mir_last[i] = 0; mir_segs[i] = 0;
    end
    for (int i = 0; i < NUM_PEERS; i++) mir_fill[i] = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: known after reset where obvious
    rows.push_back('{OP_CHECK, 0, 0, 0, 0, 1, '{ST_MISS, 0, 0, 0}});
    rows.push_back('{OP_ACCESS, 3, 63, 1023, 0, 1, '{ST_MISS, 0, 0, 0}});
    rows.push_back('{OP_ACCESS, 3, 63, 1023, 0, 1, '{ST_MISS, 0, 0, 0}});
    rows.push_back('{OP_ADD, 0, 0, 0, 5, 1, '{ST_ADDED, 0, 0, 1}});
    rows.push_back('{OP_ADD, 0, 0, 0, 6, 1, '{ST_HIT, 0, 0, 1}});
    rows.push_back('{OP_ADD, 3, 63, 1023, 32'hFFFFFFFF, 1, '{ST_ADDED, 0, 0, 1}});
    rows.push_back('{OP_CHECK, 3, 63, 1023, 7, 1, '{ST_HIT, 0, 0, 1}});
    rows.push_back('{2'd3, 1, 5, 5, 9, 1, '{ST_MISS, 0, 0, 0}});
    rows.push_back('{OP_ACCESS, 0, 0, 0, 8, 0, '0});
    rows.push_back('{OP_ACCESS, 0, 0, 0, 8, 0, '0});
    rows.push_back('{OP_ACCESS, 0, 0, 1, 2000, 0, '0});
    rows.push_back('{OP_ADD, 0, 1, 682, 2001, 0, '0});
    rows.push_back('{OP_ADD, 0, 1, 341, 2002, 0, '0});
    rows.push_back('{OP_ACCESS, 0, 1, 682, 2003, 0, '0});
    rows.push_back('{OP_ADD, 2, 42, 512, 32'h80000000, 0, '0});
    rows.push_back('{OP_CHECK, 2, 21, 512, 0, 0, '0});
    foreach (rows[i]) begin
      it = '{rows[i].op, rows[i].peer, rows[i].video, rows[i].seg, rows[i].now};
      send_item(it, 0);
      if (rows[i].known) begin
        drain();
        // typed expectation against the result just taken
        got = last_got;
        if (got !== rows[i].exp_res) begin
          $display("%0t: row %0d exp %h got %h", $time, i, rows[i].exp_res, got);
          errors++;
        end
      end
    end
    drain();

    // small cache, extremes of weights and threshold, random traffic in phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_CACHE_SIZE, 4); write_reg(CFG_TREND_LIMIT, 0); end
        1: begin write_reg(CFG_LONG_SMOOTH, 0); write_reg(CFG_SHORT_SMOOTH, 65535);
                 write_reg(CFG_TREND_LIMIT, 65535); end
        2: begin write_reg(CFG_CACHE_SIZE, 0); write_reg(CFG_LONG_SMOOTH, 65535);
                 write_reg(CFG_SHORT_SMOOTH, 0); end
        3: begin write_reg(CFG_CACHE_SIZE, 127); write_reg(CFG_TREND_LIMIT, 300); end
        4: begin write_reg(CFG_CACHE_SIZE, 2); write_reg(CFG_LONG_SMOOTH, 62259);
                 write_reg(CFG_SHORT_SMOOTH, 52429); write_reg(CFG_TREND_LIMIT, 256); end
        default: begin write_reg(CFG_CACHE_SIZE, $urandom_range(1, 12));
                 write_reg(CFG_TREND_LIMIT, $urandom_range(128, 512)); end
      endcase
      for (int n = 0; n < 200; n++) begin
        if (ph == 1 && n == 50) begin
          // long receiver hold while input keeps coming
          fork
            begin hold_long = 1; repeat (3000) @(posedge clk_i); hold_long = 0; end
          join_none
        end
        if (ph == 2 && n == 100) begin
          in_valid_i <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        send_item(rand_item(ph == 3 ? 63 : 7, ph == 3 ? 1023 : 15), 1);
      end
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ trend_aware_segment_cache_policy.f @@
design/tasc_pkg.sv
design/tasc_slot_mem.sv
design/tasc_pair_mem.sv
design/tasc_pop_unit.sv
design/trend_aware_segment_cache_policy.sv
test/tb_trend_aware_segment_cache_policy.sv
